/* rtl/core/chbe_pkg.sv */
// Package for the custom hash block engine: transaction structs, FSM states,
// chain initial value, round constant table.
// No dependencies.
package chbe_pkg;

  localparam int BLOCK_WORDS = 16;
  localparam int WORD_W = 32;
  localparam int CHAIN_WORDS = 8;
  localparam int ROUNDS = 32;

  localparam logic [WORD_W-1:0] MASK_A = 32'hABCDEFAB;
  localparam logic [WORD_W-1:0] MASK_B = 32'h77777777;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [CHAIN_WORDS-1:0][WORD_W-1:0] chain_t;

  localparam chain_t CHAIN_INIT = '{
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

  typedef struct packed {
    logic load;
    logic step;
    logic mix;
  } rnd_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_RUN,
    ST_ADD,
    ST_EMIT
  } state_t;

  function automatic logic [WORD_W-1:0] round_k(input logic [4:0] idx);
    logic [WORD_W-1:0] k;
    case (idx)
      5'd0:  k = 32'h428a2f98;
      5'd1:  k = 32'h71374491;
      5'd2:  k = 32'hb5c0fbcf;
      5'd3:  k = 32'he9b5dba5;
      5'd4:  k = 32'h3956c25b;
      5'd5:  k = 32'h59f111f1;
      5'd6:  k = 32'h923f82a4;
      5'd7:  k = 32'hab1c5ed5;
      5'd8:  k = 32'hd807aa98;
      5'd9:  k = 32'h12835b01;
      5'd10: k = 32'h243185be;
      5'd11: k = 32'h550c7dc3;
      5'd12: k = 32'h72be5d74;
      5'd13: k = 32'h80deb1fe;
      5'd14: k = 32'h9bdc06a7;
      5'd15: k = 32'hc19bf174;
      5'd16: k = 32'he49b69c1;
      5'd17: k = 32'hefbe4786;
      5'd18: k = 32'h0fc19dc6;
      5'd19: k = 32'h240ca1cc;
      5'd20: k = 32'h2de92c6f;
      5'd21: k = 32'h4a7484aa;
      5'd22: k = 32'h5cb0a9dc;
      5'd23: k = 32'h76f988da;
      5'd24: k = 32'h983e5152;
      5'd25: k = 32'ha831c66d;
      5'd26: k = 32'hb00327c8;
      5'd27: k = 32'hbf597fc7;
      5'd28: k = 32'hc6e00bf3;
      5'd29: k = 32'hd5a79147;
      5'd30: k = 32'h06ca6351;
      5'd31: k = 32'h14292967;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

/* rtl/core/chbe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module chbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/chbe_round.sv */
// Shared round unit: eight working variables and one compression round per step.
// Depends on chbe_pkg.
module chbe_round (
  input  logic              clk,
  input  chbe_pkg::rnd_ctl_t ctl,
  input  logic [31:0]       k,
  input  logic [31:0]       w,
  input  chbe_pkg::chain_t  chain,
  output chbe_pkg::chain_t  vars
);
  import chbe_pkg::*;

  chain_t v_r;
  chain_t v_nxt;
  logic [31:0] m;
  logic [31:0] im;
  logic [31:0] t1;
  logic [31:0] t2;

  assign m  = k & MASK_A;
  assign im = ~k & MASK_B;

  always_comb begin
    if (ctl.mix) begin
      t1 = v_r[7] + ((v_r[4] & m) ^ (v_r[5] & im)) + {v_r[4][12:0], v_r[4][31:13]} + w;
      t2 = ((v_r[0] & im) ^ (v_r[1] & m)) + {v_r[0][16:0], v_r[0][31:17]};
    end else begin
      t1 = v_r[7] + ({v_r[4][5:0], v_r[4][31:6]} ^ {v_r[4][10:0], v_r[4][31:11]})
         + (v_r[5] ^ v_r[6]) + k + w;
      t2 = ({v_r[0][1:0], v_r[0][31:2]} ^ {v_r[0][12:0], v_r[0][31:13]})
         + (v_r[1] ^ v_r[2]);
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (ctl.load) begin
      v_nxt = chain;
    end else if (ctl.step) begin
      v_nxt[7] = v_r[6];
      v_nxt[6] = v_r[5];
      v_nxt[5] = v_r[4];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[3] = v_r[2];
      v_nxt[2] = v_r[1];
      v_nxt[1] = v_r[0];
      v_nxt[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

  assign vars = v_r;

endmodule

/* rtl/core/custom_hash_block_engine_core.sv */
// Top level of the custom hash block engine: byte packing, padding, round
// sequencer, chain and digest output. Depends on chbe_pkg, chbe_ram, chbe_round.
//
// Usage:
//   Input: drive in_item and raise start; the transaction is taken at a
//   rising edge with start high and busy low. in_item.data_byte counts only
//   when byte_present is set; last ends the message.
//   Output: eight digest words, one per cycle, each marked by out_valid for
//   one cycle, word_index 0 first, last_word on word 7. No backpressure.
// Timing:
//   A byte that neither closes a 64-byte block nor ends the message leaves busy low.
//   A byte that closes a block holds busy through a load step, 32 rounds
//   through the single shared round unit and a chain-add step.
//   A last transaction adds padding writes to message RAM words pos/4 to 15
//   (pos = byte offset in the block), a compression and the output words;
//   the first digest word follows the add through emit and the output register.
// Reset:
//   Synchronous active-low rst_n sets the chain to its initial value, the byte
//   offset to zero and the sequencer to idle. The message RAM is not cleared.
module custom_hash_block_engine_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  chbe_pkg::in_t  in_item,
  output logic           out_valid,
  output chbe_pkg::out_t out_item
);
  import chbe_pkg::*;

  state_t state_r;
  state_t state_nxt;
  chain_t chain_r;
  chain_t chain_nxt;
  chain_t vars;
  logic [5:0]  pos_r;
  logic [5:0]  pos_nxt;
  logic [31:0] word_r;
  logic [31:0] word_nxt;
  logic [3:0]  pw_r;
  logic [3:0]  pw_nxt;
  logic [4:0]  rnd_r;
  logic [4:0]  rnd_nxt;
  logic [2:0]  e_r;
  logic [2:0]  e_nxt;
  logic        pend_r;
  logic        pend_nxt;
  logic        fin_r;
  logic        fin_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  out_t        out_r;
  out_t        out_nxt;

  logic        accept;
  logic [4:0]  sh;
  logic [31:0] base_word;
  logic [31:0] pad_word;
  logic        ram_we;
  logic [3:0]  ram_waddr;
  logic [31:0] ram_wdata;
  logic [3:0]  ram_raddr;
  logic [31:0] ram_rdata;
  rnd_ctl_t    rctl;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign sh        = {~pos_r[1:0], 3'b000};
  assign base_word = (pos_r[1:0] == 2'd0) ? '0 : word_r;
  assign word_nxt  = (accept && in_item.byte_present)
                   ? (base_word | ({24'd0, in_item.data_byte} << sh)) : word_r;
  assign pad_word  = (pw_r == pos_r[5:2]) ? (base_word | ({24'd0, PAD_BYTE} << sh)) : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.byte_present && pos_r == 6'd63) begin
            state_nxt = ST_LOAD;
          end else if (in_item.last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD:  if (pw_r == 4'd15) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_RUN;
      ST_RUN:  if (rnd_r == 5'(ROUNDS - 1)) state_nxt = ST_ADD;
      ST_ADD: begin
        if (fin_r) begin
          state_nxt = ST_EMIT;
        end else if (pend_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: if (e_r == 3'd7) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    chain_nxt     = chain_r;
    pos_nxt       = pos_r;
    pw_nxt        = pw_r;
    rnd_nxt       = rnd_r;
    e_nxt         = e_r;
    pend_nxt      = pend_r;
    fin_nxt       = fin_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r[5:2];
    ram_wdata     = word_nxt;
    ram_raddr     = 4'd0;
    rctl          = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.byte_present) begin
            pos_nxt = pos_r + 6'd1;
            ram_we  = (pos_r[1:0] == 2'd3);
          end
          pw_nxt = pos_nxt[5:2];
          if (in_item.byte_present && pos_r == 6'd63) begin
            pend_nxt = in_item.last;
          end
        end
      end
      ST_PAD: begin
        ram_we    = 1'b1;
        ram_waddr = pw_r;
        ram_wdata = pad_word;
        pend_nxt  = 1'b0;
        pw_nxt    = pw_r + 4'd1;
        if (pw_r == 4'd15) fin_nxt = 1'b1;
      end
      ST_LOAD: begin
        rctl.load = 1'b1;
        rnd_nxt   = '0;
      end
      ST_RUN: begin
        rctl.step = 1'b1;
        rctl.mix  = rnd_r[4];
        ram_raddr = rnd_r[3:0] + 4'd1;
        rnd_nxt   = rnd_r + 5'd1;
      end
      ST_ADD: begin
        for (int i = 0; i < CHAIN_WORDS; i++) begin
          chain_nxt[i] = chain_r[i] + vars[i];
        end
        pw_nxt = pos_r[5:2];
        if (fin_r) begin
          pos_nxt = '0;
          e_nxt   = '0;
        end
      end
      ST_EMIT: begin
        out_valid_nxt       = 1'b1;
        out_nxt.digest_word = chain_r[e_r];
        out_nxt.word_index  = e_r;
        out_nxt.last_word   = (e_r == 3'd7);
        e_nxt               = e_r + 3'd1;
        if (e_r == 3'd7) begin
          chain_nxt = CHAIN_INIT;
          fin_nxt   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chain_r     <= CHAIN_INIT;
      pos_r       <= '0;
      rnd_r       <= '0;
      e_r         <= '0;
      pend_r      <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chain_r     <= chain_nxt;
      pos_r       <= pos_nxt;
      rnd_r       <= rnd_nxt;
      e_r         <= e_nxt;
      pend_r      <= pend_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    pw_r   <= pw_nxt;
    out_r  <= out_nxt;
  end

  chbe_ram #(
    .WIDTH(WORD_W),
    .DEPTH(BLOCK_WORDS)
  ) u_msg_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  chbe_round u_round (
    .clk  (clk),
    .ctl  (rctl),
    .k    (round_k(rnd_r)),
    .w    (ram_rdata),
    .chain(chain_r),
    .vars (vars)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef NO_ASSERTIONS
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_EMIT))
    else $error("digest word strobed outside emit");

  a_run_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && rnd_r != 5'(ROUNDS - 1)) |=> (state_r == ST_RUN))
    else $error("round sequence cut short");

  a_last_word_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.last_word) |-> (out_r.word_index == 3'd7))
    else $error("last word flag on wrong index");

  a_pos_clear_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (pos_r == 6'd0 && fin_r))
    else $error("byte offset not cleared during digest output");

  a_pad_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAD) |-> (pw_r >= pos_r[5:2]))
    else $error("padding write below current word");
`endif

endmodule
